>>> src/iirdf1_pkg.sv
package iirdf1_pkg;

  localparam int FF_ORDER_DEF = 2;
  localparam int FB_ORDER_DEF = 2;

  localparam int CMD_W   = 2;
  localparam int TAP_W   = 2;
  localparam int SMP_W   = 12;
  localparam int COEF_W  = 32;
  localparam int ACC_W   = 32;
  localparam int ACC_SHIFT = 20;

  localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FF_WR  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FB_WR  = 2'd2;

  typedef struct packed {
    logic clear;
    logic issue;
  } mac_ctrl_t;

endpackage

>>> src/iirdf1_if.sv
interface iirdf1_in_if;
  import iirdf1_pkg::*;

  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [TAP_W-1:0]  tap_index;
  logic [COEF_W-1:0] coef_value;
  logic [SMP_W-1:0]  sample;

  modport source(output valid, cmd, tap_index, coef_value, sample, input ready);
  modport sink(input valid, cmd, tap_index, coef_value, sample, output ready);
endinterface

interface iirdf1_out_if;
  import iirdf1_pkg::*;

  logic             valid;
  logic             ready;
  logic [SMP_W-1:0] filtered;

  modport source(output valid, filtered, input ready);
  modport sink(input valid, filtered, output ready);
endinterface

>>> src/iirdf1_mac.sv
module iirdf1_mac (
  input  logic                          clk,
  input  logic                          rst_n,
  input  iirdf1_pkg::mac_ctrl_t         ctrl,
  input  logic [iirdf1_pkg::SMP_W-1:0]  hist_val,
  input  logic [iirdf1_pkg::COEF_W-1:0] coef_val,
  output logic [iirdf1_pkg::ACC_W-1:0]  acc
);
  import iirdf1_pkg::*;

  logic [SMP_W+COEF_W-1:0] prod_full;
  logic [ACC_W-1:0]        prod_r;
  logic                    prod_vld_r;
  logic [ACC_W-1:0]        acc_r;

  assign prod_full = {{COEF_W{1'b0}}, hist_val} * {{SMP_W{1'b0}}, coef_val};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctrl.issue;
    end
  end

  // product wraps to the accumulator width
  always_ff @(posedge clk) begin
    if (ctrl.issue) begin
      prod_r <= prod_full[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (prod_vld_r) begin
      acc_r <= acc_r + prod_r;
    end
  end

  assign acc = acc_r;

endmodule

>>> src/iir_direct_form_one_filter.sv
// sample item: accepted only while idle; ST_RUN, ST_FLUSH and ST_FIN follow, and the
// result is registered once the output is free, so the next item waits; one product
// per cycle through the single shared 12x32 multiply-accumulate unit
// coefficient writes: one item per cycle while idle, no result
// synchronous active-low reset clears both histories and both coefficient tables
module iir_direct_form_one_filter #(
  parameter int FF_ORDER = iirdf1_pkg::FF_ORDER_DEF,
  parameter int FB_ORDER = iirdf1_pkg::FB_ORDER_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  iirdf1_in_if.sink    in_item,
  iirdf1_out_if.source out_item
);
  import iirdf1_pkg::*;

  localparam int NUM_FF = FF_ORDER + 1;
  localparam int NUM_TERMS = NUM_FF + FB_ORDER;
  localparam int IDX_W = $clog2(NUM_TERMS);

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_FLUSH, ST_FIN} state_t;

  state_t            state_r;
  logic [IDX_W-1:0]  idx_r;
  logic              out_valid_r;
  logic [SMP_W-1:0]  out_filtered_r;

  logic [SMP_W-1:0]  in_hist_r [NUM_FF];
  logic [SMP_W-1:0]  out_hist_r [FB_ORDER];
  logic [COEF_W-1:0] ff_coef_r [NUM_FF];
  logic [COEF_W-1:0] fb_coef_r [FB_ORDER];

  logic              in_fire;
  logic              smp_fire;
  logic              res_load;
  logic [SMP_W-1:0]  res_val;
  logic [SMP_W-1:0]  hist_val;
  logic [COEF_W-1:0] coef_val;
  logic [ACC_W-1:0]  acc;
  mac_ctrl_t         mac_ctrl;

  assign in_item.ready  = (state_r == ST_IDLE);
  assign in_fire        = in_item.valid && in_item.ready;
  assign smp_fire       = in_fire && (in_item.cmd == CMD_SAMPLE);
  assign res_load       = (state_r == ST_FIN) && (!out_valid_r || out_item.ready);
  assign res_val        = acc[ACC_SHIFT+SMP_W-1:ACC_SHIFT];

  assign out_item.valid    = out_valid_r;
  assign out_item.filtered = out_filtered_r;

  assign mac_ctrl.clear = smp_fire;
  assign mac_ctrl.issue = (state_r == ST_RUN);

  // feedforward terms first, then feedback terms, oldest first
  always_comb begin
    hist_val = '0;
    coef_val = '0;
    for (int k = 0; k < NUM_FF; k++) begin
      if (idx_r == IDX_W'(k)) begin
        hist_val = in_hist_r[k];
        coef_val = ff_coef_r[k];
      end
    end
    for (int k = 0; k < FB_ORDER; k++) begin
      if (idx_r == IDX_W'(NUM_FF + k)) begin
        hist_val = out_hist_r[k];
        coef_val = fb_coef_r[k];
      end
    end
  end

  iirdf1_mac u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (mac_ctrl),
    .hist_val (hist_val),
    .coef_val (coef_val),
    .acc      (acc)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_item.ready && !res_load) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          idx_r <= '0;
          if (smp_fire) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (idx_r == IDX_W'(NUM_TERMS - 1)) begin
            state_r <= ST_FLUSH;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        ST_FLUSH: begin
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (res_load) begin
            out_valid_r    <= 1'b1;
            out_filtered_r <= res_val;
            state_r        <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_FF; k++) begin
        in_hist_r[k] <= '0;
        ff_coef_r[k] <= '0;
      end
      for (int k = 0; k < FB_ORDER; k++) begin
        out_hist_r[k] <= '0;
        fb_coef_r[k]  <= '0;
      end
    end else begin
      if (smp_fire) begin
        for (int k = 0; k < NUM_FF - 1; k++) begin
          in_hist_r[k] <= in_hist_r[k+1];
        end
        in_hist_r[NUM_FF-1] <= in_item.sample;
      end
      if (res_load) begin
        for (int k = 0; k < FB_ORDER - 1; k++) begin
          out_hist_r[k] <= out_hist_r[k+1];
        end
        out_hist_r[FB_ORDER-1] <= res_val;
      end
      // out-of-range slots match no entry and are dropped
      if (in_fire && (in_item.cmd == CMD_FF_WR)) begin
        for (int k = 0; k < NUM_FF; k++) begin
          if (32'(in_item.tap_index) == k) begin
            ff_coef_r[k] <= in_item.coef_value;
          end
        end
      end
      if (in_fire && (in_item.cmd == CMD_FB_WR)) begin
        for (int k = 0; k < FB_ORDER; k++) begin
          if (32'(in_item.tap_index) == k) begin
            fb_coef_r[k] <= in_item.coef_value;
          end
        end
      end
    end
  end

endmodule

>>> src/iirdf1_checker.sv
module iirdf1_props (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_ready,
  input logic [iirdf1_pkg::CMD_W-1:0]          in_cmd,
  input logic                                  out_valid,
  input logic                                  out_ready,
  input logic [iirdf1_pkg::SMP_W-1:0]          out_filtered
);
  import iirdf1_pkg::*;

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  // a sample occupies the block, so the next item waits
  a_busy_after_sample: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_cmd == CMD_SAMPLE) |=> !in_ready)
    else $error("ready after sample accept");

  // coefficient writes and unused codes leave the block free
  a_free_after_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (in_cmd != CMD_SAMPLE) |=> in_ready)
    else $error("not ready after non-sample item");

  // a new result only ever appears at the end of a busy stretch
  a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without work");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_filtered))
    else $error("stalled result changed");

endmodule

bind iir_direct_form_one_filter iirdf1_props u_iirdf1_props (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_item.valid),
  .in_ready     (in_item.ready),
  .in_cmd       (in_item.cmd),
  .out_valid    (out_item.valid),
  .out_ready    (out_item.ready),
  .out_filtered (out_item.filtered)
);

>>> tb/sv/iirdf1_checker.sv
`timescale 1ns / 1ps
module iirdf1_checker (
  input  logic        clk,
  input  logic        rst_n,
  iirdf1_in_if        in_mon,
  iirdf1_out_if       out_mon,
  output int unsigned n_fail,
  output int unsigned n_pending
);
  import iirdf1_pkg::*;

  localparam int NUM_FF = FF_ORDER_DEF + 1;
  localparam int NUM_FB = FB_ORDER_DEF;

  logic [SMP_W-1:0]  x_hist [NUM_FF];
  logic [SMP_W-1:0]  y_hist [NUM_FB];
  logic [COEF_W-1:0] ff_tab [NUM_FF];
  logic [COEF_W-1:0] fb_tab [NUM_FB];
  logic [SMP_W-1:0]  filtered_q [$];

  // push the sample, run both dot products in wrapping 32-bit math, update the
  // output history and return the filtered value
  function automatic logic [SMP_W-1:0] filter_sample(input logic [SMP_W-1:0] x);
    logic [ACC_W-1:0] acc;
    logic [SMP_W-1:0] y;
    acc = '0;
    for (int k = 0; k < NUM_FF - 1; k++) x_hist[k] = x_hist[k+1];
    x_hist[NUM_FF-1] = x;
    for (int k = 0; k < NUM_FF; k++) acc = acc + ACC_W'(x_hist[k]) * ff_tab[k];
    for (int k = 0; k < NUM_FB; k++) acc = acc + ACC_W'(y_hist[k]) * fb_tab[k];
    y = acc[ACC_SHIFT +: SMP_W];
    for (int k = 0; k < NUM_FB - 1; k++) y_hist[k] = y_hist[k+1];
    y_hist[NUM_FB-1] = y;
    return y;
  endfunction

  always @(posedge clk) begin
    logic [SMP_W-1:0] exp_y;
    if (!rst_n) begin
      for (int k = 0; k < NUM_FF; k++) begin
        x_hist[k] = '0;
        ff_tab[k] = '0;
      end
      for (int k = 0; k < NUM_FB; k++) begin
        y_hist[k] = '0;
        fb_tab[k] = '0;
      end
      filtered_q.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        case (in_mon.cmd)
          CMD_SAMPLE: begin
            filtered_q.push_back(filter_sample(in_mon.sample));
          end
          CMD_FF_WR: begin
            if (in_mon.tap_index < NUM_FF) ff_tab[in_mon.tap_index] = in_mon.coef_value;
          end
          CMD_FB_WR: begin
            if (in_mon.tap_index < NUM_FB) fb_tab[in_mon.tap_index] = in_mon.coef_value;
          end
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (filtered_q.size() == 0) begin
          $error("filtered: unexpected item, actual %0d", out_mon.filtered);
          n_fail = n_fail + 1;
        end else begin
          exp_y = filtered_q.pop_front();
          if (out_mon.filtered !== exp_y) begin
            $error("filtered mismatch: expected %0d, actual %0d", exp_y, out_mon.filtered);
            n_fail = n_fail + 1;
          end
        end
      end
    end
    n_pending = filtered_q.size();
  end

endmodule

>>> tb/sv/iir_direct_form_one_filter_tb.sv
`timescale 1ns / 1ps
module iir_direct_form_one_filter_tb;
  import iirdf1_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [COEF_W-1:0] COEF_ONE  = 32'h0010_0000;
  localparam logic [COEF_W-1:0] COEF_HALF = 32'h0008_0000;
  localparam logic [COEF_W-1:0] COEF_MAX  = 32'hFFFF_FFFF;
  localparam logic [SMP_W-1:0]  SMP_MAX   = 12'hFFF;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst_n;

  iirdf1_in_if  in_bus();
  iirdf1_out_if out_bus();

  int unsigned n_fail;
  int unsigned n_pending;
  int unsigned cycle_cnt = 0;
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  bit hold_go = 1'b0;

  iir_direct_form_one_filter u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_bus),
    .out_item (out_bus)
  );

  iirdf1_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_bus),
    .out_mon   (out_bus),
    .n_fail    (n_fail),
    .n_pending (n_pending)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("iir_direct_form_one_filter verification failed");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off while the sender keeps pushing
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_bus.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [TAP_W-1:0] tap,
                           input logic [COEF_W-1:0] coef, input logic [SMP_W-1:0] smp);
    while ($urandom_range(99) < src_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.cmd        <= cmd;
    in_bus.tap_index  <= tap;
    in_bus.coef_value <= coef;
    in_bus.sample     <= smp;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_sample(input logic [SMP_W-1:0] smp);
    send_item(CMD_SAMPLE, TAP_W'($urandom), $urandom, smp);
  endtask

  // mostly samples, with coefficient reloads (some to dead slots) and unused codes
  task automatic send_random(input int count);
    int unsigned pick;
    logic [CMD_W-1:0]  cmd;
    logic [COEF_W-1:0] coef;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 62)      cmd = CMD_SAMPLE;
      else if (pick < 78) cmd = CMD_FF_WR;
      else if (pick < 94) cmd = CMD_FB_WR;
      else                cmd = CMD_UNUSED;
      case ($urandom_range(3))
        0: coef = $urandom_range(COEF_ONE);
        1: coef = COEF_MAX - $urandom_range(COEF_ONE);
        default: coef = $urandom;
      endcase
      send_item(cmd, TAP_W'($urandom_range(3)), coef, SMP_W'($urandom));
    end
  endtask

  task automatic set_idle(input int unsigned src_pct, input int unsigned sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  initial begin
    rst_n             <= 1'b0;
    in_bus.valid      <= 1'b0;
    in_bus.cmd        <= CMD_SAMPLE;
    in_bus.tap_index  <= '0;
    in_bus.coef_value <= '0;
    in_bus.sample     <= '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // zero coefficients, unused code and writes to slots past each table
    send_sample(SMP_MAX);
    send_item(CMD_UNUSED, '0, COEF_MAX, SMP_MAX);
    send_item(CMD_FF_WR, TAP_W'(FF_ORDER_DEF + 1), COEF_MAX, '0);
    send_item(CMD_FB_WR, TAP_W'(FB_ORDER_DEF), COEF_MAX, '0);
    send_item(CMD_FB_WR, TAP_W'(FB_ORDER_DEF + 1), COEF_MAX, '0);
    send_sample(SMP_MAX);

    // unity on the oldest tap, all-ones on the newest, half feedback
    send_item(CMD_FF_WR, 2'd0, COEF_ONE, '0);
    send_item(CMD_FF_WR, 2'd1, '0, '0);
    send_item(CMD_FF_WR, 2'd2, COEF_MAX, '0);
    send_item(CMD_FB_WR, 2'd0, '0, '0);
    send_item(CMD_FB_WR, 2'd1, COEF_HALF, '0);
    send_sample('0);
    send_sample(SMP_MAX);
    send_sample(SMP_MAX);
    send_sample(12'd1);
    send_sample(12'h800);

    // every coefficient but the oldest feedforward tap at full scale: wraps the accumulator hard
    send_item(CMD_FF_WR, 2'd1, COEF_MAX, '0);
    send_item(CMD_FB_WR, 2'd0, COEF_MAX, '0);
    send_item(CMD_FB_WR, 2'd1, COEF_MAX, '0);
    send_sample(SMP_MAX);
    send_sample(SMP_MAX);
    send_sample('0);
    send_sample(SMP_MAX);

    set_idle(0, 0);
    send_random(180);
    set_idle(67, 0);
    send_random(240);
    set_idle(0, 67);
    send_random(240);
    set_idle(35, 35);
    send_random(190);

    // long hold-off on the result side with the sender never idle
    set_idle(0, 0);
    hold_go = 1'b1;
    send_random(100);

    in_bus.valid <= 1'b0;
    @(negedge clk);
    while (n_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (n_fail == 0) begin
      $display("iir_direct_form_one_filter verification clean");
    end else begin
      $display("iir_direct_form_one_filter verification failed");
    end
    $finish;
  end

endmodule
